// File: rtl/first_fit_heap_allocator_defines.svh
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FFHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FFHA_ASSERT_IMP(label, ante, cons)
`define FFHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/ffha_pkg.sv
// shared types and codes of the first-fit heap allocator
package ffha_pkg;
	localparam int CALC_W = 16;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_INIT    = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOMEM    = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;

	localparam logic CFG_HEAP_SIZE = 1'b0;
	localparam logic CFG_MIN_SIZE  = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [12:0] data_size;
		logic [11:0] user_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] data_offset;
		logic [12:0] granted_size;
	} rsp_t;

	// field write enables of the node store
	typedef struct packed {
		logic size;
		logic mark;
		logic nxt;
		logic prv;
	} store_we_t;
endpackage

// File: rtl/ffha_store.sv
// node store: size/mark memory and link memory, field writes, registered read
module ffha_store #(
	parameter int AW = 12,
	parameter int SW = 13
) (
	input  logic                clk,
	input  ffha_pkg::store_we_t we,
	input  logic [AW-1:0]       waddr,
	input  logic [SW-1:0]       wsize,
	input  logic                wmark,
	input  logic [AW:0]         wnext,
	input  logic [AW:0]         wprev,
	input  logic [AW-1:0]       raddr,
	output logic [SW-1:0]       rsize,
	output logic                rmark,
	output logic [AW:0]         rnext,
	output logic [AW:0]         rprev
);
	localparam int DEPTH = 1 << AW;

	typedef struct packed {
		logic          mark;
		logic [SW-1:0] size;
	} node_t;

	typedef struct packed {
		logic [AW:0] nxt;
		logic [AW:0] prv;
	} link_t;

	node_t node_mem [DEPTH];
	link_t link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.size) node_mem[waddr].size <= wsize;
		if (we.mark) node_mem[waddr].mark <= wmark;
		if (we.nxt) link_mem[waddr].nxt <= wnext;
		if (we.prv) link_mem[waddr].prv <= wprev;
		rsize <= node_mem[raddr].size;
		rmark <= node_mem[raddr].mark;
		rnext <= link_mem[raddr].nxt;
		rprev <= link_mem[raddr].prv;
	end
endmodule

// File: rtl/first_fit_heap_allocator.sv
// first-fit free-list heap allocator, top level
//
// channel | dir | handshake             | word
// req     | in  | req_valid/req_ready   | ffha_pkg::req_t (req_type, data_size, user_addr)
// rsp     | out | rsp_valid/rsp_ready   | ffha_pkg::rsp_t (status, data_offset, granted_size)
// cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (heap_size, min_size)
//
// allocate: reads each free node in turn until one fits, then relinks and answers
// free: a marked node goes to the list head; else, or outside the heap, NOTALLOC
// unknown request or empty list: answered without reading the store
// reinitialize and reset: a clearing pass over all MAX_HEAP entries of the node store
// the store read is registered, so each node is read in S_WAIT and tested in S_EVAL
// a finished word waits in the response register; the next request is taken meanwhile
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
	parameter int MAX_HEAP     = 4096,
	parameter int HEADER_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ffha_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ffha_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [12:0]    cfg_data
);
	localparam int AW  = $clog2(MAX_HEAP);
	localparam int SW  = $clog2(MAX_HEAP + 1);
	localparam int STW = $clog2(MAX_HEAP + 1);
	localparam int CW  = ffha_pkg::CALC_W;
	// link: top bit marks the null link
	localparam logic [AW:0] LINK_NIL = {1'b1, {AW{1'b0}}};

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_WAIT, S_EVAL, S_SPLIT, S_W1, S_W2, S_W3, S_W4,
		S_FWAIT, S_FEVAL, S_FPUSH, S_RESP
	} state_t;

	state_t         state_q;
	logic [12:0]    heap_size_q, min_size_q;
	logic [AW-1:0]  cur_q, rem_q, clr_q;
	logic [AW:0]    head_q, prev_q, next_q;
	logic [SW-1:0]  size_q;
	logic [CW-1:0]  need_q, take_q;
	logic           split_q, rep_q, init_q;
	logic [STW-1:0] steps_q;
	ffha_pkg::rsp_t pend_q, rsp_q;
	logic           rsp_valid_q;

	// store port
	ffha_pkg::store_we_t we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wsize, rsize;
	logic          wmark, rmark;
	logic [AW:0]   wnext, wprev, rnext, rprev;

	ffha_store #(.AW(AW), .SW(SW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wsize (wsize),
		.wmark (wmark),
		.wnext (wnext),
		.wprev (wprev),
		.raddr (cur_q),
		.rsize (rsize),
		.rmark (rmark),
		.rnext (rnext),
		.rprev (rprev)
	);

	// heap size clipped to what the store holds
	logic [CW-1:0] eff_heap;
	assign eff_heap = (CW'(heap_size_q) > CW'(MAX_HEAP)) ? CW'(MAX_HEAP) : CW'(heap_size_q);

	// free address checks
	logic [CW-1:0] nd;
	logic          free_ok;
	assign nd      = CW'(req.user_addr) - CW'(HEADER_BYTES);
	assign free_ok = (CW'(req.user_addr) >= CW'(HEADER_BYTES)) && (nd < eff_heap)
		&& (nd < CW'(MAX_HEAP));

	// fit test on the node just read
	logic [CW-1:0] sz_ext, rem_sum;
	logic          fit, walk_end;
	assign sz_ext   = CW'(rsize);
	assign fit      = sz_ext >= need_q;
	assign walk_end = rnext[AW] || (steps_q == STW'(MAX_HEAP - 1));
	assign rem_sum  = CW'(cur_q) + take_q;

	// replacement link of the node leaving the list
	logic [AW:0] rep_link;
	assign rep_link = rep_q ? {1'b0, rem_q} : next_q;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	logic rsp_load;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	// store writes, one entry per cycle
	always_comb begin
		we    = '0;
		waddr = cur_q;
		wsize = '0;
		wmark = 1'b0;
		wnext = LINK_NIL;
		wprev = LINK_NIL;
		case (state_q)
			S_CLEAR: begin
				we    = '{size: 1'b1, mark: 1'b1, nxt: 1'b1, prv: 1'b1};
				waddr = clr_q;
				wsize = (clr_q == '0) ? SW'(eff_heap) : '0;
			end
			S_W1: begin
				we    = '{size: 1'b1, mark: 1'b1, nxt: 1'b1, prv: 1'b1};
				waddr = rem_q;
				wsize = size_q - SW'(take_q);
				wnext = next_q;
				wprev = prev_q;
			end
			S_W2: begin
				// mark the taken node and drop its links
				we.mark = 1'b1;
				we.size = rep_q;
				we.nxt  = 1'b1;
				we.prv  = 1'b1;
				wmark   = 1'b1;
				wsize   = SW'(take_q);
			end
			S_W3: begin
				if (!next_q[AW]) begin
					we.prv = 1'b1;
					waddr  = next_q[AW-1:0];
					wprev  = rep_q ? {1'b0, rem_q} : prev_q;
				end
			end
			S_W4: begin
				// next link of the node before it
				if (!prev_q[AW]) begin
					we.nxt = 1'b1;
					waddr  = prev_q[AW-1:0];
					wnext  = rep_link;
				end
			end
			S_FEVAL: begin
				if (rmark) begin
					we.mark = 1'b1;
					we.nxt  = 1'b1;
					we.prv  = 1'b1;
					wnext   = head_q;
				end
			end
			S_FPUSH: begin
				if (!head_q[AW]) begin
					we.prv = 1'b1;
					waddr  = head_q[AW-1:0];
					wprev  = {1'b0, cur_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			heap_size_q <= 13'd4096;
			min_size_q  <= 13'd16;
			clr_q       <= '0;
			head_q      <= '0;
			init_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ffha_pkg::CFG_HEAP_SIZE) heap_size_q <= cfg_data;
				else min_size_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready && !rsp_load) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q  <= clr_q + 1'b1;
					head_q <= '0;
					if (clr_q == AW'(MAX_HEAP - 1)) begin
						clr_q <= '0;
						if (init_q) begin
							pend_q  <= '{status: ffha_pkg::ST_OK, data_offset: '0,
								granted_size: 13'(eff_heap)};
							state_q <= S_RESP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						pend_q <= '{status: ffha_pkg::ST_OK, data_offset: '0,
							granted_size: '0};
						case (req.req_type)
							ffha_pkg::REQ_ALLOC: begin
								need_q  <= CW'(req.data_size) + CW'(HEADER_BYTES);
								steps_q <= '0;
								cur_q   <= head_q[AW-1:0];
								if (head_q[AW]) begin
									pend_q.status <= ffha_pkg::ST_NOMEM;
									state_q       <= S_RESP;
								end else begin
									state_q <= S_WAIT;
								end
							end
							ffha_pkg::REQ_FREE: begin
								cur_q <= nd[AW-1:0];
								if (free_ok) begin
									state_q <= S_FWAIT;
								end else begin
									pend_q.status <= ffha_pkg::ST_NOTALLOC;
									state_q       <= S_RESP;
								end
							end
							ffha_pkg::REQ_INIT: begin
								init_q  <= 1'b1;
								state_q <= S_CLEAR;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_WAIT: state_q <= S_EVAL;
				S_EVAL: begin
					if (fit) begin
						size_q  <= rsize;
						prev_q  <= rprev;
						next_q  <= rnext;
						take_q  <= (need_q < CW'(min_size_q)) ? CW'(min_size_q) : need_q;
						split_q <= (sz_ext - need_q) > CW'(min_size_q);
						state_q <= S_SPLIT;
					end else if (walk_end) begin
						pend_q.status <= ffha_pkg::ST_NOMEM;
						state_q       <= S_RESP;
					end else begin
						cur_q   <= rnext[AW-1:0];
						steps_q <= steps_q + 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_SPLIT: begin
					rep_q <= split_q && (rem_sum < CW'(MAX_HEAP));
					rem_q <= rem_sum[AW-1:0];
					pend_q.data_offset <= 12'(CW'(cur_q) + CW'(HEADER_BYTES));
					if (split_q && (rem_sum < CW'(MAX_HEAP))) begin
						pend_q.granted_size <= 13'(take_q);
						state_q <= S_W1;
					end else begin
						pend_q.granted_size <= 13'(size_q);
						state_q <= S_W2;
					end
				end
				S_W1: state_q <= S_W2;
				S_W2: begin
					if (prev_q[AW]) head_q <= rep_link;
					state_q <= S_W3;
				end
				S_W3: state_q <= S_W4;
				S_W4: state_q <= S_RESP;
				S_FWAIT: state_q <= S_FEVAL;
				S_FEVAL: begin
					if (rmark) begin
						pend_q.granted_size <= 13'(rsize);
						state_q <= S_FPUSH;
					end else begin
						pend_q.status <= ffha_pkg::ST_NOTALLOC;
						state_q       <= S_RESP;
					end
				end
				S_FPUSH: begin
					head_q  <= {1'b0, cur_q};
					state_q <= S_RESP;
				end
				S_RESP: begin
					init_q <= 1'b0;
					if (rsp_load) begin
						rsp_q       <= pend_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FFHA_ASSERT_NEXT(a_rsp_loaded, rsp_load, rsp_valid_q)
	`FFHA_ASSERT_IMP(a_no_req_while_busy, state_q != S_IDLE, !req_ready)
	`FFHA_ASSERT_IMP(a_alloc_grant, rsp_load && pend_q.status == ffha_pkg::ST_OK && pend_q.data_offset != '0, pend_q.granted_size != '0)
endmodule
